/* rtl/assert_macros.svh */
// assertion helpers for the keystroke remapper checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked only outside reset
`define KMR_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// checked on every edge, reset included
`define KMR_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

/* rtl/kmr_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package kmr_pkg;

  // input item kinds, carried on the slave tuser
  localparam logic [1:0] OP_KEY  = 2'd0;
  localparam logic [1:0] OP_HDR  = 2'd1;
  localparam logic [1:0] OP_CODE = 2'd2;

  // queued command kinds
  localparam logic [1:0] CMD_HDR  = 2'd0;
  localparam logic [1:0] CMD_CODE = 2'd1;
  localparam logic [1:0] CMD_PASS = 2'd2;
  localparam logic [1:0] CMD_LOOK = 2'd3;

  localparam logic [15:0] HALT_CODE = 16'd1;
  localparam logic [15:0] EXT_BASE  = 16'd1000;
  localparam logic [15:0] EXT_FLAG  = 16'd2;

  localparam int MAX_OUT     = 16;
  localparam int NW          = $clog2(MAX_OUT + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QW          = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [1:0]  kind;
    logic [3:0]  slot;
    logic [3:0]  pos;
    logic [7:0]  device;
    logic [15:0] code;
    logic [15:0] kstate;
    logic [31:0] info;
    logic [15:0] value;
    logic        enable;
  } kmr_cmd_t;

endpackage

`default_nettype wire

/* rtl/kmr_fifo.sv */
`timescale 1ns / 1ps
`default_nettype none

module kmr_fifo import kmr_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire logic     push,
  input  var  kmr_cmd_t push_cmd,
  output logic          full,
  input  wire logic     pop,
  output logic          not_empty,
  output kmr_cmd_t      head
);

  kmr_cmd_t        mem [QUEUE_DEPTH];
  logic [QW-1:0]   wr_ptr;
  logic [QW-1:0]   rd_ptr;
  logic [QW:0]     count;

  assign full      = (count == (QW+1)'(QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

`default_nettype wire

/* rtl/kmr_front.sv */
`timescale 1ns / 1ps
`default_nettype none

module kmr_front import kmr_pkg::*; #(
  parameter int ENTRIES         = 16,
  parameter int CODES_PER_ENTRY = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [103:0] s_axis_tdata,
  input  wire logic [1:0]   s_axis_tuser,
  input  wire logic         clearing,
  input  wire logic         q_full,
  output logic              push,
  output kmr_cmd_t          cmd
);

  logic stopped;
  logic accept;
  logic keep;
  logic halt;
  logic slot_ok;
  logic pos_ok;

  assign s_axis_tready = !clearing && !q_full;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    cmd.slot   = s_axis_tdata[3:0];
    cmd.pos    = s_axis_tdata[7:4];
    cmd.device = s_axis_tdata[15:8];
    cmd.code   = s_axis_tdata[32:17];
    cmd.kstate = s_axis_tdata[48:33];
    cmd.info   = s_axis_tdata[80:49];
    cmd.value  = s_axis_tdata[96:81];
    cmd.enable = s_axis_tdata[97];
    slot_ok    = (32'(cmd.slot) < ENTRIES);
    pos_ok     = (32'(cmd.pos) < CODES_PER_ENTRY);
    keep       = 1'b0;
    halt       = 1'b0;
    cmd.kind   = CMD_PASS;
    case (s_axis_tuser)
      OP_KEY: begin
        if (stopped) begin
          // a stopped block passes code 1 too
          cmd.kind = CMD_PASS;
          keep     = 1'b1;
        end else if (cmd.code == HALT_CODE) begin
          // halts whether or not the device was readable
          halt = 1'b1;
        end else if (!s_axis_tdata[16]) begin
          // unreadable device
          cmd.kind = CMD_PASS;
          keep     = 1'b1;
        end else begin
          cmd.kind = CMD_LOOK;
          keep     = 1'b1;
        end
      end
      OP_HDR: begin
        cmd.kind = CMD_HDR;
        keep     = slot_ok;
      end
      OP_CODE: begin
        cmd.kind = CMD_CODE;
        keep     = slot_ok && pos_ok;
      end
      default: begin
        keep = 1'b0;
      end
    endcase
  end

  assign push = accept && keep;

  always_ff @(posedge clk) begin
    if (rst) begin
      stopped <= 1'b0;
    end else if (accept && halt) begin
      stopped <= 1'b1;
    end
  end

endmodule

`default_nettype wire

/* rtl/kmr_back.sv */
`timescale 1ns / 1ps
`default_nettype none

module kmr_back import kmr_pkg::*; #(
  parameter int ENTRIES         = 16,
  parameter int CODES_PER_ENTRY = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        q_valid,
  input  var  kmr_cmd_t    q_cmd,
  output logic             q_pop,
  output logic             clearing,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata,
  output logic             m_axis_tlast
);

  localparam int SW    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int PW    = (CODES_PER_ENTRY > 1) ? $clog2(CODES_PER_ENTRY) : 1;
  localparam int DEPTH = ENTRIES * CODES_PER_ENTRY;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HREQ  = 3'd2;
  localparam logic [2:0] ST_HCHK  = 3'd3;
  localparam logic [2:0] ST_CREQ  = 3'd4;
  localparam logic [2:0] ST_CCHK  = 3'd5;
  localparam logic [2:0] ST_FLUSH = 3'd6;
  localparam logic [2:0] ST_PASS  = 3'd7;

  logic [2:0]         state;
  logic [AW-1:0]      clr_addr;
  logic [ENTRIES-1:0] slot_valid;
  logic [23:0]        hdr_mem [ENTRIES];
  logic [15:0]        code_mem [DEPTH];
  logic [23:0]        hdr_rdata;
  logic [15:0]        code_rdata;
  kmr_cmd_t           cmd;
  logic [SW-1:0]      s;
  logic [PW-1:0]      p;
  logic [NW-1:0]      n;
  logic [15:0]        run_st;
  logic               pend_valid;
  logic [15:0]        pend_code;
  logic [15:0]        pend_state;
  logic               out_valid;
  logic [15:0]        out_code;
  logic [15:0]        out_state;
  logic [31:0]        out_info;
  logic               out_last;

  logic               out_free;
  logic               out_load;
  logic               ext;
  logic [15:0]        st_adj;
  logic [15:0]        oc;
  logic               hdr_hit;
  logic               hdr_we;
  logic               code_we;
  logic [AW-1:0]      code_waddr;
  logic [15:0]        code_wdata;
  logic [AW-1:0]      code_raddr;
  logic [SW-1:0]      q_slot;

  assign clearing = (state == ST_CLEAR);
  assign q_pop    = (state == ST_IDLE) && q_valid;
  assign q_slot   = SW'(q_cmd.slot);
  assign out_free = !out_valid || m_axis_tready;

  // a new beat enters the output register this cycle
  assign out_load = out_free && (((state == ST_CCHK) && (code_rdata != 16'd0) && pend_valid)
                                 || (state == ST_FLUSH) || (state == ST_PASS));

  always_comb begin
    ext = (code_rdata > EXT_BASE);
    oc  = ext ? code_rdata - EXT_BASE : code_rdata;
    if (ext) begin
      st_adj = (run_st < EXT_FLAG) ? run_st + EXT_FLAG : run_st;
    end else begin
      st_adj = (run_st > 16'd1) ? run_st - EXT_FLAG : run_st;
    end
  end

  assign hdr_hit    = slot_valid[s] && (hdr_rdata == {cmd.device, cmd.code});
  assign hdr_we     = q_pop && (q_cmd.kind == CMD_HDR);
  assign code_we    = clearing || (q_pop && (q_cmd.kind == CMD_CODE));
  assign code_waddr = clearing ? clr_addr
                    : AW'(32'(q_cmd.slot) * CODES_PER_ENTRY + 32'(q_cmd.pos));
  assign code_wdata = clearing ? 16'd0 : q_cmd.value;
  assign code_raddr = AW'(32'(s) * CODES_PER_ENTRY + 32'(p));

  // header store: device tag above trigger
  always_ff @(posedge clk) begin
    if (hdr_we) begin
      hdr_mem[q_slot] <= {q_cmd.device, q_cmd.code};
    end
    if (state == ST_HREQ) begin
      hdr_rdata <= hdr_mem[s];
    end
  end

  always_ff @(posedge clk) begin
    if (code_we) begin
      code_mem[code_waddr] <= code_wdata;
    end
    if (state == ST_CREQ) begin
      code_rdata <= code_mem[code_raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_CLEAR;
      clr_addr   <= '0;
      slot_valid <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          if (clr_addr == AW'(DEPTH - 1)) begin
            state <= ST_IDLE;
          end else begin
            clr_addr <= clr_addr + 1'b1;
          end
        end
        ST_IDLE: begin
          if (q_valid) begin
            cmd <= q_cmd;
            case (q_cmd.kind)
              CMD_HDR:  slot_valid[q_slot] <= q_cmd.enable;
              CMD_PASS: state <= ST_PASS;
              CMD_LOOK: begin
                s     <= '0;
                state <= ST_HREQ;
              end
              default:  state <= ST_IDLE;
            endcase
          end
        end
        ST_HREQ: begin
          state <= ST_HCHK;
        end
        ST_HCHK: begin
          if (hdr_hit) begin
            p      <= '0;
            n      <= '0;
            run_st <= cmd.kstate;
            state  <= ST_CREQ;
          end else if (s == SW'(ENTRIES - 1)) begin
            state <= ST_PASS;
          end else begin
            s     <= s + 1'b1;
            state <= ST_HREQ;
          end
        end
        ST_CREQ: begin
          state <= ST_CCHK;
        end
        ST_CCHK: begin
          if (code_rdata != 16'd0) begin
            if (!pend_valid || out_free) begin
              // the held stroke is not the final one
              if (pend_valid) begin
                out_code  <= pend_code;
                out_state <= pend_state;
                out_info  <= cmd.info;
                out_last  <= 1'b0;
              end
              pend_valid <= 1'b1;
              pend_code  <= oc;
              pend_state <= st_adj;
              run_st     <= st_adj;
              n          <= n + 1'b1;
              if ((n == NW'(MAX_OUT - 1)) || (p == PW'(CODES_PER_ENTRY - 1))) begin
                state <= ST_FLUSH;
              end else begin
                p     <= p + 1'b1;
                state <= ST_CREQ;
              end
            end
          end else if (p == PW'(CODES_PER_ENTRY - 1)) begin
            if (pend_valid) begin
              state <= ST_FLUSH;
            end else if (s == SW'(ENTRIES - 1)) begin
              state <= ST_PASS;
            end else begin
              // empty slot, keep searching
              s     <= s + 1'b1;
              state <= ST_HREQ;
            end
          end else begin
            p     <= p + 1'b1;
            state <= ST_CREQ;
          end
        end
        ST_FLUSH: begin
          if (out_free) begin
            out_code   <= pend_code;
            out_state  <= pend_state;
            out_info   <= cmd.info;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= ST_IDLE;
          end
        end
        ST_PASS: begin
          if (out_free) begin
            out_code  <= cmd.code;
            out_state <= cmd.kstate;
            out_info  <= cmd.info;
            out_last  <= 1'b1;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {out_info, out_state, out_code};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

/* rtl/keystroke_macro_remapper.sv */
`timescale 1ns / 1ps
`default_nettype none

// Keystroke macro remapper. Load beats (tuser 1 header, 2 code) fill a table of
// ENTRIES slots, each with a device tag, a trigger code and CODES_PER_ENTRY
// replacement codes; a keystroke beat (tuser 0) from a readable device whose tag
// and code match the lowest valid slot holding a nonzero code comes out as one
// beat per nonzero code (at most 16), tlast on the final one, with codes above
// 1000 sent as code-1000 and the extended flag in the state adjusted; anything
// unclaimed passes through as one beat, and key code 1 halts remapping for good.
// After reset the code store is cleared one entry a cycle, with s_axis_tready
// low throughout. The back end works one command at a time from a two-deep
// queue: a load is written to the stores as it is popped, and a direct pass-through
// goes out from a pass state. A lookup reads the slot headers from the lowest slot
// up and, for each matching slot, reads its codes in position order; every header
// and code read goes through a request state and then a check state, set by the
// single read port of the header and code stores. A miss scans every header and
// passes the keystroke through; a stalled output holds the back end.

module keystroke_macro_remapper import kmr_pkg::*; #(
  parameter int ENTRIES         = 16,
  parameter int CODES_PER_ENTRY = 16
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // slot[3:0], position[7:4], device_tag[15:8], device_id_ok[16],
  // key_code[32:17], key_state[48:33], key_info[80:49], entry_value[96:81],
  // slot_enable[97], zero pad above
  input  wire logic [103:0] s_axis_tdata,
  // opcode[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // out_code[15:0], out_state[31:16], out_info[63:32]
  output logic [63:0]       m_axis_tdata,
  // last
  output logic              m_axis_tlast
);

  // front to queue
  logic     push;
  kmr_cmd_t push_cmd;
  logic     q_full;

  // queue to back
  logic     q_valid;
  logic     q_pop;
  kmr_cmd_t q_head;

  // back end busy with the store clearing pass
  logic     clearing;

  // front: classify beats, track the halt flag, drop what needs no work
  kmr_front #(
    .ENTRIES         (ENTRIES),
    .CODES_PER_ENTRY (CODES_PER_ENTRY)
  ) u_front (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .clearing      (clearing),
    .q_full        (q_full),
    .push          (push),
    .cmd           (push_cmd)
  );

  // command queue keeps loads ordered behind earlier keystrokes
  kmr_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_valid),
    .head      (q_head)
  );

  // back: table stores, slot scan, stroke emission
  kmr_back #(
    .ENTRIES         (ENTRIES),
    .CODES_PER_ENTRY (CODES_PER_ENTRY)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_valid       (q_valid),
    .q_cmd         (q_head),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

`default_nettype wire

/* rtl/kmr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module kmr_checker (
  input wire logic         clk,
  input wire logic         rst,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [103:0] s_axis_tdata,
  input wire logic [1:0]   s_axis_tuser,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [63:0]  m_axis_tdata,
  input wire logic         m_axis_tlast
);

  logic in_beat;

  assign in_beat = s_axis_tvalid && s_axis_tready;

  // a stalled output beat holds
  `KMR_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "output beat changed while stalled")

  // clearing pass follows reset, so no input is taken right after it
  `KMR_ASSERT_ALWAYS(a_clear_after_rst, rst |=> !s_axis_tready, "input taken during store clearing")

  // nothing is emitted right after reset
  `KMR_ASSERT_ALWAYS(a_quiet_after_rst, rst |=> !m_axis_tvalid, "output beat right after reset")

  // an accepted input beat carries known data
  `KMR_ASSERT(a_in_known, in_beat |-> !$isunknown({s_axis_tuser, s_axis_tdata}), "unknown bits in accepted input beat")

  // an offered output beat carries known data
  `KMR_ASSERT(a_out_known, m_axis_tvalid |-> !$isunknown({m_axis_tdata, m_axis_tlast}), "unknown bits in output beat")

endmodule

bind keystroke_macro_remapper kmr_checker u_kmr_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .s_axis_tdata  (s_axis_tdata),
  .s_axis_tuser  (s_axis_tuser),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);

`default_nettype wire

/* tb/sv/tb_keystroke_macro_remapper.sv */
`timescale 1ns / 1ps

module tb_keystroke_macro_remapper;
  import kmr_pkg::*;

  localparam int NUM_SLOTS      = 16;
  localparam int NUM_POSITIONS  = 16;
  localparam int RANDOM_ITEMS   = 190;
  localparam int QUIET_TAIL     = 40;     // last random items run without idling
  localparam int WATCHDOG_LIMIT = 3000;   // covers the table clearing pass and slow lookups
  localparam int DRAIN_CYCLES   = 120;    // full slot scan plus a full remap
  localparam int MAX_REPORTS    = 10;

  // opcode value the block must ignore
  localparam logic [1:0] OP_UNUSED = 2'd3;

  typedef struct {
    logic [1:0]  opcode;
    logic [3:0]  slot;
    logic [3:0]  position;
    logic [7:0]  device_tag;
    logic        device_id_ok;
    logic [15:0] key_code;
    logic [15:0] key_state;
    logic [31:0] key_info;
    logic [15:0] entry_value;
    logic        slot_enable;
  } kmr_item_t;

  typedef struct {
    logic [15:0] out_code;
    logic [15:0] out_state;
    logic [31:0] out_info;
    logic        last;
  } stroke_t;

  // mirror of the macro table plus the queue of strokes still owed
  class keystroke_scoreboard;
    bit          slot_on[NUM_SLOTS];
    bit [7:0]    slot_dev[NUM_SLOTS];
    bit [15:0]   slot_trig[NUM_SLOTS];
    bit [15:0]   slot_code[NUM_SLOTS][NUM_POSITIONS];
    bit          halted;
    stroke_t     expected_strokes[$];
    int          errors;
    int          keys_seen;
    int          remaps;
    int          strokes_checked;

    function int pending();
      return expected_strokes.size();
    endfunction

    function bit slot_has_codes(int s);
      for (int p = 0; p < NUM_POSITIONS; p++)
        if (slot_code[s][p] != 16'd0) return 1'b1;
      return 1'b0;
    endfunction

    function void push_pass(kmr_item_t it);
      stroke_t st;
      st.out_code  = it.key_code;
      st.out_state = it.key_state;
      st.out_info  = it.key_info;
      st.last      = 1'b1;
      expected_strokes.insert(expected_strokes.size(), st);
    endfunction

    // replaces a matched keystroke with the slot's nonzero codes
    function void remap_keystroke(kmr_item_t it, int s);
      stroke_t     st;
      logic [15:0] running;
      logic [15:0] c;
      int          n;
      int          first;
      running = it.key_state;
      n = 0;
      first = expected_strokes.size();
      for (int p = 0; p < NUM_POSITIONS && n < MAX_OUT; p++) begin
        c = slot_code[s][p];
        if (c != 16'd0) begin
          if (c > EXT_BASE) begin
            st.out_code = c - EXT_BASE;
            if (running < EXT_FLAG) running = running + EXT_FLAG;
          end else begin
            st.out_code = c;
            if (running > 16'd1) running = running - EXT_FLAG;
          end
          st.out_state = running;
          st.out_info  = it.key_info;
          st.last      = 1'b0;
          expected_strokes.insert(expected_strokes.size(), st);
          n++;
        end
      end
      expected_strokes[first + n - 1].last = 1'b1;
      remaps++;
    endfunction

    function void note_item(kmr_item_t it);
      int hit;
      case (it.opcode)
        OP_HDR: begin
          slot_on[it.slot]   = it.slot_enable;
          slot_dev[it.slot]  = it.device_tag;
          slot_trig[it.slot] = it.key_code;
        end
        OP_CODE: slot_code[it.slot][it.position] = it.entry_value;
        OP_KEY: begin
          keys_seen++;
          if (halted) begin
            push_pass(it);
          end else if (it.key_code == HALT_CODE) begin
            halted = 1'b1;
          end else begin
            hit = -1;
            if (it.device_id_ok)
              for (int s = 0; s < NUM_SLOTS && hit < 0; s++)
                if (slot_on[s] && slot_dev[s] == it.device_tag &&
                    slot_trig[s] == it.key_code && slot_has_codes(s))
                  hit = s;
            if (hit >= 0) remap_keystroke(it, hit);
            else push_pass(it);
          end
        end
        default: ;
      endcase
    endfunction

    function void check_stroke(stroke_t got);
      stroke_t want;
      strokes_checked++;
      if (expected_strokes.size() == 0) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("unexpected stroke code=%h state=%h info=%h last=%b",
                   got.out_code, got.out_state, got.out_info, got.last);
        return;
      end
      want = expected_strokes.pop_front();
      if (got.out_code !== want.out_code || got.out_state !== want.out_state ||
          got.out_info !== want.out_info || got.last !== want.last) begin
        errors++;
        if (errors <= MAX_REPORTS) begin
          $display("stroke mismatch: expected code=%h state=%h info=%h last=%b",
                   want.out_code, want.out_state, want.out_info, want.last);
          $display("                 got      code=%h state=%h info=%h last=%b",
                   got.out_code, got.out_state, got.out_info, got.last);
        end
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [103:0] s_axis_tdata = '0;
  logic [1:0]   s_axis_tuser = OP_KEY;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [63:0]  m_axis_tdata;
  logic         m_axis_tlast;

  keystroke_scoreboard sb = new();
  bit          quiet = 1'b0;     // no idling on either side when set
  int          idle_cycles = 0;
  int          items_sent = 0;
  int          stall_left = 0;
  logic [7:0]  dev_pool[4];
  logic [15:0] trig_pool[4];

  always #1 clk = ~clk;

  keystroke_macro_remapper u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  // output side: check accepted beats, then pick the next ready value
  always @(posedge clk) begin
    stroke_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got.out_code  = m_axis_tdata[15:0];
      got.out_state = m_axis_tdata[31:16];
      got.out_info  = m_axis_tdata[63:32];
      got.last      = m_axis_tlast;
      sb.check_stroke(got);
    end
    if (stall_left > 0) begin
      stall_left--;
      m_axis_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(0, 6);
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // watchdog: cycles without any beat moving on either side
  always @(posedge clk) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= WATCHDOG_LIMIT);
    $display("watchdog expired with %0d strokes outstanding", sb.pending());
    $display("keystroke_macro_remapper verification failed");
    $finish;
  end

  function automatic kmr_item_t mk(logic [1:0] op, logic [3:0] slot, logic [3:0] pos,
                                   logic [7:0] dev, logic ok, logic [15:0] code,
                                   logic [15:0] kst, logic [31:0] info,
                                   logic [15:0] val, logic en);
    kmr_item_t it;
    it.opcode       = op;
    it.slot         = slot;
    it.position     = pos;
    it.device_tag   = dev;
    it.device_id_ok = ok;
    it.key_code     = code;
    it.key_state    = kst;
    it.key_info     = info;
    it.entry_value  = val;
    it.slot_enable  = en;
    return it;
  endfunction

  // one input beat, with an optional gap ahead of it
  task automatic send_beat(kmr_item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= it.opcode;
    s_axis_tdata  <= {6'd0, it.slot_enable, it.entry_value, it.key_info, it.key_state,
                      it.key_code, it.device_id_ok, it.device_tag, it.position, it.slot};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(it);
    items_sent++;
  endtask

  // replacement code mix: empty, boundary, plain and extended values
  function automatic logic [15:0] pick_code();
    case ($urandom_range(0, 9))
      0:       return 16'd0;
      1:       return EXT_BASE;
      2:       return EXT_BASE + 16'd1;
      3:       return 16'hffff;
      4, 5, 6: return 16'($urandom_range(1, 1000));
      default: return 16'($urandom_range(1001, 65535));
    endcase
  endfunction

  function automatic logic [15:0] pick_state();
    if ($urandom_range(0, 1) == 0) return 16'($urandom_range(0, 3));
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] no_halt(logic [15:0] code);
    return (code == HALT_CODE) ? 16'd2 : code;
  endfunction

  // mostly well-formed: program slots, then strike keys that hit them
  task automatic run_random(int count);
    int          done;
    int          roll;
    int          s;
    int          n;
    logic [7:0]  dev;
    logic [15:0] trig;
    done = 0;
    while (done < count) begin
      if (count - done <= QUIET_TAIL) quiet = 1'b1;
      roll = $urandom_range(0, 99);
      if (roll < 15) begin
        s    = $urandom_range(0, NUM_SLOTS - 1);
        dev  = $urandom_range(0, 3) != 0 ? dev_pool[$urandom_range(0, 3)] : 8'($urandom);
        trig = $urandom_range(0, 3) != 0 ? trig_pool[$urandom_range(0, 3)] : 16'($urandom);
        send_beat(mk(OP_HDR, 4'(s), 4'($urandom), dev, 1'($urandom), trig,
                     16'($urandom), $urandom, 16'($urandom), $urandom_range(0, 9) != 0));
        done++;
        if ($urandom_range(0, 3) == 0) begin
          // full slot: sixteen nonzero codes, sixteen strokes
          for (int p = 0; p < NUM_POSITIONS; p++) begin
            send_beat(mk(OP_CODE, 4'(s), 4'(p), 8'($urandom), 1'($urandom), 16'($urandom),
                         16'($urandom), $urandom, pick_code() | 16'd1, 1'($urandom)));
            done++;
          end
        end else begin
          n = $urandom_range(1, 4);
          repeat (n) begin
            send_beat(mk(OP_CODE, 4'(s), 4'($urandom), 8'($urandom), 1'($urandom),
                         16'($urandom), 16'($urandom), $urandom, pick_code(),
                         1'($urandom)));
            done++;
          end
        end
      end else if (roll < 65) begin
        if ($urandom_range(0, 9) < 7) begin
          s    = $urandom_range(0, NUM_SLOTS - 1);
          dev  = sb.slot_dev[s];
          trig = sb.slot_trig[s];
        end else begin
          dev  = $urandom_range(0, 1) ? dev_pool[$urandom_range(0, 3)] : 8'($urandom);
          trig = 16'($urandom);
        end
        send_beat(mk(OP_KEY, 4'($urandom), 4'($urandom), dev, $urandom_range(0, 6) != 0,
                     no_halt(trig), pick_state(), $urandom, 16'($urandom), 1'($urandom)));
        done++;
      end else if (roll < 85) begin
        send_beat(mk(OP_CODE, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom), $urandom, pick_code(), 1'($urandom)));
        done++;
      end else if (roll < 93) begin
        send_beat(mk(OP_HDR, 4'($urandom), 4'($urandom), dev_pool[$urandom_range(0, 3)],
                     1'($urandom), trig_pool[$urandom_range(0, 3)], 16'($urandom),
                     $urandom, 16'($urandom), 1'($urandom)));
        done++;
      end else begin
        // unused opcode, ignored by the block
        send_beat(mk(OP_UNUSED, 4'($urandom), 4'($urandom), 8'($urandom), 1'($urandom),
                     16'($urandom), 16'($urandom), $urandom, 16'($urandom), 1'($urandom)));
      end
    end
  endtask

  initial begin
    dev_pool  = '{8'h00, 8'hff, 8'($urandom), 8'($urandom)};
    trig_pool = '{16'h0000, 16'hffff, 16'($urandom_range(2, 65535)),
                  16'($urandom_range(2, 65535))};
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed: empty table, slot without codes, boundaries, lowest slot wins
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, 16'h0000, 16'h0000, 32'h0, 16'h0, 1'b0));
    send_beat(mk(OP_HDR,  4'd0,  4'd0,  8'h00, 1'b0, 16'h0000, 16'h0000, 32'h0, 16'h0, 1'b1));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, 16'h0000, 16'h0001, 32'h0, 16'h0, 1'b0));
    send_beat(mk(OP_HDR,  4'd3,  4'd0,  8'h00, 1'b1, 16'h0000, 16'h0000, 32'h0, 16'h0, 1'b1));
    send_beat(mk(OP_CODE, 4'd3,  4'd0,  8'h00, 1'b0, 16'h0000, 16'h0000, 32'h0,
                 EXT_BASE + 16'd1, 1'b0));
    send_beat(mk(OP_CODE, 4'd3,  4'd7,  8'h00, 1'b0, 16'h0000, 16'h0000, 32'h0, 16'hffff, 1'b0));
    send_beat(mk(OP_CODE, 4'd3,  4'd15, 8'h00, 1'b0, 16'h0000, 16'h0000, 32'h0, EXT_BASE, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, 16'h0000, 16'h0000, 32'h0, 16'h0, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, 16'h0000, 16'hffff, 32'hffffffff,
                 16'h0, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, 16'h0000, 16'h0002, 32'h12345678,
                 16'h0, 1'b0));
    // unreadable device passes through
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b0, 16'h0000, 16'h0000, 32'h1, 16'h0, 1'b0));
    send_beat(mk(OP_HDR,  4'd15, 4'd15, 8'hff, 1'b1, 16'hffff, 16'hffff, 32'hffffffff,
                 16'hffff, 1'b1));
    send_beat(mk(OP_CODE, 4'd15, 4'd15, 8'hff, 1'b1, 16'hffff, 16'hffff, 32'hffffffff,
                 16'd2, 1'b1));
    send_beat(mk(OP_KEY,  4'd15, 4'd15, 8'hff, 1'b1, 16'hffff, 16'h0003, 32'hffffffff,
                 16'hffff, 1'b1));
    send_beat(mk(OP_HDR,  4'd14, 4'd0,  8'hff, 1'b1, 16'hffff, 16'h0000, 32'h0, 16'h0, 1'b1));
    send_beat(mk(OP_CODE, 4'd14, 4'd0,  8'h00, 1'b0, 16'h0000, 16'h0000, 32'h0, 16'd500, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'hff, 1'b1, 16'hffff, 16'h0001, 32'h0badf00d,
                 16'h0, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'hfe, 1'b1, 16'hffff, 16'h0000, 32'h5, 16'h0, 1'b0));
    send_beat(mk(OP_UNUSED, 4'hf, 4'hf, 8'hff, 1'b1, 16'hffff, 16'hffff, 32'hffffffff,
                 16'hffff, 1'b1));
    send_beat(mk(OP_HDR,  4'd3,  4'd0,  8'h00, 1'b0, 16'h0000, 16'h0000, 32'h0, 16'h0, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, 16'h0000, 16'h0000, 32'h7, 16'h0, 1'b0));

    run_random(RANDOM_ITEMS);

    // halt key, then loads still land but every keystroke passes through
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, HALT_CODE, 16'h0000, 32'h0, 16'h0, 1'b0));
    send_beat(mk(OP_HDR,  4'd1,  4'd0,  8'h5a, 1'b1, 16'h0033, 16'h0000, 32'h0, 16'h0, 1'b1));
    send_beat(mk(OP_CODE, 4'd1,  4'd0,  8'h5a, 1'b1, 16'h0000, 16'h0000, 32'h0, 16'd1234, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h5a, 1'b1, 16'h0033, 16'h0002, 32'hcafe, 16'h0, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'h00, 1'b1, HALT_CODE, 16'h0001, 32'h9, 16'h0, 1'b0));
    send_beat(mk(OP_KEY,  4'd0,  4'd0,  8'hff, 1'b1, 16'hffff, 16'h0000, 32'ha, 16'h0, 1'b0));
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("sent %0d beats: %0d keystrokes, %0d remapped, %0d strokes checked",
             items_sent, sb.keys_seen, sb.remaps, sb.strokes_checked);
    $display("%0d stroke mismatches", sb.errors);
    if (sb.errors == 0)
      $display("keystroke_macro_remapper verification clean");
    else
      $display("keystroke_macro_remapper verification failed");
    $finish;
  end

endmodule
